@@ hw/rtl/dds_pkg.sv @@
`default_nettype none
package dds_pkg;

   localparam int TABLE_DEPTH = 256;

   localparam int PHASE_W  = 16;
   localparam int STEP_W   = 11;
   localparam int FREQ_W   = 13;
   localparam int COUNT_W  = 8;
   localparam int SAMPLE_W = 8;
   localparam int TIDX_W   = 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = FREQ_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQUENCY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_DELAY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_WIDTH = 2'd2;

   localparam logic [STEP_W-1:0]  STEP_RESET        = 11'd800;
   localparam logic [COUNT_W-1:0] SYNC_DELAY_RESET  = 8'd10;
   localparam logic [COUNT_W-1:0] PULSE_WIDTH_RESET = 8'd10;

   // ceil(2^16 / 5): exact floor(f / 5) for any 13-bit f after >> 16
   localparam int RECIP_W = 14;
   localparam logic [RECIP_W-1:0] DIV5_RECIP = 14'd13108;

   // item modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TIMER  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/dds_ifs.sv @@
`default_nettype none
interface dds_req_if;
   logic                              valid;
   logic                              ready;
   logic [dds_pkg::MODE_W-1:0]        mode;
   logic [dds_pkg::TIDX_W-1:0]        table_index;
   logic [dds_pkg::SAMPLE_W-1:0]      table_value;

   modport source (output valid, mode, table_index, table_value, input ready);
   modport sink   (input valid, mode, table_index, table_value, output ready);
endinterface

interface dds_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dds_pkg::SAMPLE_W-1:0]      sample;
   logic                              pulse_active;
   logic                              wrapped;

   modport source (output valid, sample, pulse_active, wrapped, input ready);
   modport sink   (input valid, sample, pulse_active, wrapped, output ready);
endinterface

interface dds_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dds_pkg::CSR_IDX_W-1:0]     index;
   logic [dds_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dds_sine_with_delayed_sync_pulse.sv @@
// DDS waveform generator with a delayed sync pulse.
// req_chan carries one item per transfer: a sample tick advances the phase
// accumulator and looks the sample up in the waveform memory, a pulse-timer
// tick counts the sync pulse down, a table write stores one waveform entry.
// Every item gives exactly one transfer on rsp_chan (sample, pulse level,
// wrap flag). csr_chan writes frequency, sync delay and pulse width; it is
// always ready and is only to be written while no item is in flight.
// The result is registered: it is valid after the edge that accepts the
// item, with the sample taken from the memory's registered read.
// Throughput is one item per cycle while rsp_chan is ready; the memory's
// single read/write port and the output register set that figure.
// A table write followed at once by a sample tick of the same entry reads
// the new value, since the write lands at the earlier edge.
// When rsp_chan stalls, the output register holds and req_chan.ready drops
// until the result is taken.
// Reset clears phase, counters and pulse, loads the default configuration
// and needs no clearing pass; the waveform memory is undefined until written.
// TABLE_DEPTH must be a power of two from 16 to 4096.
`default_nettype none
module dds_sine_with_delayed_sync_pulse #(
   parameter int TABLE_DEPTH = dds_pkg::TABLE_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dds_req_if.sink    req_chan,
   dds_rsp_if.source  rsp_chan,
   dds_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PW = dds_pkg::PHASE_W;
   localparam int CW = dds_pkg::COUNT_W;
   localparam int PROD_W = dds_pkg::FREQ_W + dds_pkg::RECIP_W;

   // configuration
   logic [dds_pkg::STEP_W-1:0] step_ff;
   logic [CW-1:0]              sync_delay_ff;
   logic [CW-1:0]              pulse_width_ff;
   logic [PROD_W-1:0]          step_prod;

   // scalar state
   logic [PW-1:0] phase_ff, phase_in;
   logic [CW-1:0] delay_ff, delay_in;
   logic [CW-1:0] pulse_left_ff, pulse_left_in;
   logic          level_ff, level_in;
   logic [dds_pkg::SAMPLE_W-1:0] last_sample_ff;

   // output stage
   logic                         out_valid_ff;
   logic                         out_is_sample_ff;
   logic                         out_pulse_ff;
   logic                         out_wrapped_ff;
   logic [dds_pkg::SAMPLE_W-1:0] rd_data_ff;

   // waveform memory
   logic [dds_pkg::SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];

   logic          req_xfer, rsp_xfer;
   logic          is_sample, is_timer, is_write;
   logic [PW:0]   phase_sum;
   logic          wrap;
   logic [CW-1:0] delay_load;
   logic [CW-1:0] delay_dec;
   logic [CW-1:0] pulse_dec;
   logic [AW-1:0] rd_idx, wr_idx;

   assign csr_chan.ready = 1'b1;
   assign step_prod = PROD_W'(csr_chan.data) * PROD_W'(dds_pkg::DIV5_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= dds_pkg::STEP_RESET;
         sync_delay_ff  <= dds_pkg::SYNC_DELAY_RESET;
         pulse_width_ff <= dds_pkg::PULSE_WIDTH_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            dds_pkg::CSR_FREQUENCY:   step_ff        <= step_prod[PROD_W-1 -: dds_pkg::STEP_W];
            dds_pkg::CSR_SYNC_DELAY:  sync_delay_ff  <= csr_chan.data[CW-1:0];
            dds_pkg::CSR_PULSE_WIDTH: pulse_width_ff <= csr_chan.data[CW-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = out_valid_ff && rsp_chan.ready;

   assign is_sample = (req_chan.mode == dds_pkg::MODE_SAMPLE);
   assign is_timer  = (req_chan.mode == dds_pkg::MODE_TIMER);
   assign is_write  = (req_chan.mode == dds_pkg::MODE_WRITE);

   assign phase_sum  = {1'b0, phase_ff} + (PW + 1)'(step_ff);
   assign wrap       = phase_sum[PW];
   assign delay_load = wrap ? sync_delay_ff : delay_ff;
   assign delay_dec  = delay_load - 1'b1;
   assign pulse_dec  = pulse_left_ff - 1'b1;

   assign rd_idx = phase_sum[PW-1 -: AW];
   assign wr_idx = AW'(req_chan.table_index);

   always_comb begin
      phase_in      = phase_ff;
      delay_in      = delay_ff;
      pulse_left_in = pulse_left_ff;
      level_in      = level_ff;
      if (is_sample) begin
         phase_in = phase_sum[PW-1:0];
         delay_in = delay_load;
         if (delay_load != '0) begin
            delay_in = delay_dec;
            if (delay_dec == '0) begin
               // delay ran out: (re)start the pulse
               pulse_left_in = pulse_width_ff;
               level_in      = 1'b1;
            end
         end
      end else if (is_timer && level_ff) begin
         pulse_left_in = pulse_dec;
         if (pulse_dec == '0) begin
            level_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         delay_ff      <= '0;
         pulse_left_ff <= '0;
         level_ff      <= 1'b0;
      end else if (req_xfer) begin
         phase_ff      <= phase_in;
         delay_ff      <= delay_in;
         pulse_left_ff <= pulse_left_in;
         level_ff      <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && is_write) begin
         wave_mem[wr_idx] <= req_chan.table_value;
      end
      if (req_xfer && is_sample) begin
         rd_data_ff <= wave_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         out_is_sample_ff <= is_sample;
         out_pulse_ff     <= level_in;
         out_wrapped_ff   <= is_sample && wrap;
      end
   end

   // held sample for items that do no lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
      end else if (rsp_xfer && out_is_sample_ff) begin
         last_sample_ff <= rd_data_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sample       = out_is_sample_ff ? rd_data_ff : last_sample_ff;
   assign rsp_chan.pulse_active = out_pulse_ff;
   assign rsp_chan.wrapped      = out_wrapped_ff;

endmodule
`default_nettype wire
